/* hdl/ils_pkg.sv */
`default_nettype none

package ils_pkg;

  // Field widths of the two channels
  localparam int MODE_W     = 3;
  localparam int INDEX_W    = 6;
  localparam int VALUE_W    = 32;
  localparam int READ_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 7;

  // Parameter defaults
  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Operation codes on the mode field
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_APPEND = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // What every cell of the row does to its word
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_APPEND = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     rd_hit;
    status_t  status;
  } ctrl_res_t;

endpackage

`default_nettype wire

/* hdl/ils_if.sv */
`default_nettype none

interface ils_in_if import ils_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [INDEX_W-1:0] index;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output mode, output index, output value, input ready);
  modport sink   (input valid, input mode, input index, input value, output ready);
endinterface

interface ils_out_if import ils_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [READ_W-1:0]   read_value;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  item_count;
  logic                is_empty;

  modport source (output valid, output read_value, output status, output item_count,
                  output is_empty, input ready);
  modport sink   (input valid, input read_value, input status, input item_count,
                  input is_empty, output ready);
endinterface

`default_nettype wire

/* hdl/ils_cell.sv */
`default_nettype none

module ils_cell import ils_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int IDX_W      = 6,
  parameter int POS        = 0
) (
  input  wire logic                  clk,
  input  wire cell_op_t              op,
  input  wire logic [IDX_W-1:0]      pos,
  input  wire logic [DATA_WIDTH-1:0] data_in,
  input  wire logic [DATA_WIDTH-1:0] left_i,
  input  wire logic [DATA_WIDTH-1:0] right_i,
  output logic      [DATA_WIDTH-1:0] word_o,
  output logic      [DATA_WIDTH-1:0] tap_o
);

  localparam logic [IDX_W-1:0] MY_POS = IDX_W'(POS);

  logic [DATA_WIDTH-1:0] word_r;
  logic [DATA_WIDTH-1:0] word_nxt;
  logic                  at_pos;
  logic                  above_pos;

  assign at_pos    = (pos == MY_POS);
  assign above_pos = (MY_POS > pos);

  always_comb begin
    word_nxt = word_r;
    case (op)
      OP_INSERT: begin
        if (at_pos) begin
          word_nxt = data_in;
        end else if (above_pos) begin
          word_nxt = left_i;
        end
      end
      OP_REMOVE: begin
        if (at_pos || above_pos) begin
          word_nxt = right_i;
        end
      end
      OP_APPEND: begin
        if (at_pos) begin
          word_nxt = data_in;
        end
      end
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_o = word_r;
  // Drive the read bus only from the addressed cell
  assign tap_o  = at_pos ? word_r : '0;

endmodule

`default_nettype wire

/* hdl/ils_ctrl.sv */
`default_nettype none

module ils_ctrl import ils_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int IDX_W    = 6,
  parameter int CNT_W    = 7
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire logic [MODE_W-1:0]  mode,
  input  wire logic [INDEX_W-1:0] index,
  output ctrl_res_t               res,
  output logic      [IDX_W-1:0]   pos,
  output logic      [CNT_W-1:0]   count_nxt
);

  localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

  logic [CNT_W-1:0] count_r;
  logic [CMP_W-1:0] idx_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             in_range;
  logic             full;
  logic             idx_zero;

  assign idx_ext  = CMP_W'(index);
  assign cnt_ext  = CMP_W'(count_r);
  assign in_range = (idx_ext < cnt_ext);
  assign full     = (count_r == CAP);
  assign idx_zero = (index == '0);

  always_comb begin
    res.op     = OP_HOLD;
    res.rd_hit = 1'b0;
    res.status = ST_OK;
    pos        = idx_ext[IDX_W-1:0];
    count_nxt  = count_r;
    case (mode)
      MODE_READ: begin
        if (in_range) begin
          res.rd_hit = 1'b1;
        end else begin
          res.status = ST_RANGE;
        end
      end
      MODE_INSERT: begin
        if (!idx_zero && !in_range) begin
          res.status = ST_RANGE;
        end else if (full) begin
          res.status = ST_FULL;
        end else begin
          res.op    = OP_INSERT;
          count_nxt = count_r + ONE;
        end
      end
      MODE_APPEND: begin
        pos = count_r[IDX_W-1:0];
        if (full) begin
          res.status = ST_FULL;
        end else begin
          res.op    = OP_APPEND;
          count_nxt = count_r + ONE;
        end
      end
      MODE_DELETE: begin
        if (in_range) begin
          res.op    = OP_REMOVE;
          count_nxt = count_r - ONE;
        end else begin
          res.status = ST_RANGE;
        end
      end
      MODE_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        res.op = OP_HOLD;
      end
    endcase
    // No shift without a transaction
    if (!accept) begin
      res.op = OP_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/indexed_list_store_core.sv */
`default_nettype none

// Channel   Direction  Fields                                     Handshake
// in_ch     sink       mode[3], index[6], value[32]               valid/ready
// out_ch    source     read_value[32], status[2], item_count[7],  valid/ready
//                      is_empty[1]
//
// One transaction per cycle while the output is not stalled: every cell of
// the row updates at the edge that accepts an item, so insert and delete
// move all later words at once. The result is registered at that edge.
// Input is taken while the output register is empty or being emptied.
// Reset clears the element count and output valid; cell words are not reset.

module indexed_list_store_core import ils_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ils_in_if.sink    in_ch,
  ils_out_if.source out_ch
);

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int DEXT_W = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
  localparam int CEXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  logic                  accept;
  ctrl_res_t             res;
  logic [IDX_W-1:0]      pos;
  logic [CNT_W-1:0]      count_nxt;
  logic [DEXT_W-1:0]     val_ext;
  logic [DATA_WIDTH-1:0] data_in;
  logic [DATA_WIDTH-1:0] cell_word [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_tap  [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_word;
  logic [DEXT_W-1:0]     rd_ext;
  logic [CEXT_W-1:0]     cnt_ext;

  logic                  out_valid_r;
  logic [READ_W-1:0]     read_value_r;
  status_t               status_r;
  logic [COUNT_W-1:0]    item_count_r;
  logic                  is_empty_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign val_ext = DEXT_W'(in_ch.value);
  assign data_in = val_ext[DATA_WIDTH-1:0];

  ils_ctrl #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .mode      (in_ch.mode),
    .index     (in_ch.index),
    .res       (res),
    .pos       (pos),
    .count_nxt (count_nxt)
  );

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;

    if (k == 0) begin : g_first
      assign left_w = data_in;
    end else begin : g_mid_l
      assign left_w = cell_word[k-1];
    end

    // Last cell keeps its own word on removal; it lies beyond the count
    if (k == CAPACITY - 1) begin : g_last
      assign right_w = cell_word[k];
    end else begin : g_mid_r
      assign right_w = cell_word[k+1];
    end

    ils_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W),
      .POS        (k)
    ) u_cell (
      .clk     (clk),
      .op      (res.op),
      .pos     (pos),
      .data_in (data_in),
      .left_i  (left_w),
      .right_i (right_w),
      .word_o  (cell_word[k]),
      .tap_o   (cell_tap[k])
    );
  end

  always_comb begin
    rd_word = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_word = rd_word | cell_tap[k];
    end
  end

  assign rd_ext  = DEXT_W'(rd_word);
  assign cnt_ext = CEXT_W'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_value_r <= res.rd_hit ? rd_ext[READ_W-1:0] : '0;
      status_r     <= res.status;
      item_count_r <= cnt_ext[COUNT_W-1:0];
      is_empty_r   <= (count_nxt == '0);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = read_value_r;
  assign out_ch.status     = status_r;
  assign out_ch.item_count = item_count_r;
  assign out_ch.is_empty   = is_empty_r;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import ils_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned RANDOM_ITEMS = 1525;
  localparam int unsigned PHASE_LEN    = 120;
  localparam int unsigned LONG_HOLD    = 300;

  // Mode codes that the block must treat as no-ops
  localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = MODE_CLEAR + MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = '1;

  typedef enum {PH_GROW, PH_MIXED, PH_SHRINK, PH_BURST} phase_t;

  typedef struct packed {
    logic [READ_W-1:0]   read_value;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  item_count;
    logic                is_empty;
  } list_result_t;

  class list_scoreboard;
    logic [VALUE_W-1:0] words[$];
    list_result_t       awaited_q[$];
    int unsigned        errors;

    function int unsigned count();
      return words.size();
    endfunction

    function int unsigned outstanding();
      return awaited_q.size();
    endfunction

    function void report(string what, logic [READ_W-1:0] exp_v, logic [READ_W-1:0] got_v);
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, exp_v, got_v);
    endfunction

    // Apply one accepted transaction to the list and queue the result it should give
    function void note_request(logic [MODE_W-1:0] mode, logic [INDEX_W-1:0] idx,
                               logic [VALUE_W-1:0] val);
      list_result_t res;
      logic         in_range;
      logic         full;
      in_range       = idx < words.size();
      full           = words.size() >= CAPACITY_DEF;
      res.read_value = '0;
      res.status     = ST_OK;
      case (mode)
        MODE_READ: begin
          if (in_range) res.read_value = words[idx];
          else res.status = ST_RANGE;
        end
        MODE_INSERT: begin
          // index is checked before fullness
          if (idx != 0 && !in_range) res.status = ST_RANGE;
          else if (full) res.status = ST_FULL;
          else words.insert(idx, val);
        end
        MODE_APPEND: begin
          if (full) res.status = ST_FULL;
          else words.push_back(val);
        end
        MODE_DELETE: begin
          if (in_range) words.delete(idx);
          else res.status = ST_RANGE;
        end
        MODE_CLEAR: words.delete();
        default: ;
      endcase
      res.item_count = COUNT_W'(words.size());
      res.is_empty   = (words.size() == 0);
      awaited_q.push_back(res);
    endfunction

    function void check_result(list_result_t got);
      list_result_t exp;
      if (awaited_q.size() == 0) begin
        report("unexpected result, read_value", '0, got.read_value);
        return;
      end
      exp = awaited_q.pop_front();
      if (got.read_value !== exp.read_value) report("read_value", exp.read_value, got.read_value);
      if (got.status !== exp.status) report("status", exp.status, got.status);
      if (got.item_count !== exp.item_count) report("item_count", exp.item_count, got.item_count);
      if (got.is_empty !== exp.is_empty) report("is_empty", exp.is_empty, got.is_empty);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int unsigned cycle_count;
  phase_t phase;
  list_scoreboard sb = new();

  ils_in_if  in_ch();
  ils_out_if out_ch();

  indexed_list_store_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.read_value, out_ch.status, out_ch.item_count, out_ch.is_empty});
  end

  // Result side: random stalls, stretches without stalls, and two long hold-offs
  initial begin
    int unsigned rx_cycles;
    int unsigned hold_left;
    int unsigned run_left;
    int unsigned r;
    rx_cycles    = 0;
    hold_left    = 0;
    run_left     = 0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      rx_cycles++;
      if (hold_left == 0 && run_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 20) begin
          run_left = $urandom_range(40, 150);
        end else begin
          run_left  = $urandom_range(1, 8);
          hold_left = (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        end
      end
      // let the block fill up while the sender keeps offering
      if (rx_cycles == 800 || rx_cycles == 3000) hold_left = LONG_HOLD;
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = 1'b1;
        run_left--;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (phase == PH_BURST || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode();
    int unsigned r;
    r = $urandom_range(0, 99);
    case (phase)
      PH_GROW: begin
        if (r < 45) return MODE_APPEND;
        if (r < 80) return MODE_INSERT;
        if (r < 92) return MODE_READ;
        return MODE_DELETE;
      end
      PH_SHRINK: begin
        if (r < 45) return MODE_DELETE;
        if (r < 72) return MODE_READ;
        if (r < 82) return MODE_INSERT;
        if (r < 92) return MODE_APPEND;
      end
      default: begin
        if (r < 30) return MODE_READ;
        if (r < 52) return MODE_INSERT;
        if (r < 72) return MODE_APPEND;
        if (r < 92) return MODE_DELETE;
      end
    endcase
    if (r < 97) return MODE_CLEAR;
    return MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index(logic [MODE_W-1:0] mode);
    int unsigned n;
    n = sb.count();
    if ($urandom_range(0, 99) < 15) return INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
    if (n == 0) return '0;
    // insert may also name the slot just past the end, which is out of range
    if (mode == MODE_INSERT) return (n > 63) ? INDEX_W'(63) : INDEX_W'($urandom_range(0, n));
    return INDEX_W'($urandom_range(0, n - 1));
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 8) return '1;
    return $urandom;
  endfunction

  task automatic send_request(logic [MODE_W-1:0] mode, logic [INDEX_W-1:0] idx,
                              logic [VALUE_W-1:0] val, int unsigned gap);
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.mode  = mode;
    in_ch.index = idx;
    in_ch.value = val;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_request(mode, idx, val);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  initial begin
    logic [MODE_W-1:0] mode;
    cycle_count = 0;
    phase       = PH_MIXED;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode  = MODE_READ;
    in_ch.index = '0;
    in_ch.value = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty list: every indexed access is out of range except insert at the front
    send_request(MODE_READ,   0,     32'h0,        pick_gap());
    send_request(MODE_DELETE, 0,     32'h0,        pick_gap());
    send_request(MODE_INSERT, 5,     32'h1234_5678, pick_gap());
    send_request(MODE_INSERT, 0,     32'hFFFF_FFFF, pick_gap());
    send_request(MODE_APPEND, 6'd63, 32'h0000_0000, pick_gap());
    send_request(MODE_APPEND, 0,     32'hA5A5_A5A5, pick_gap());
    send_request(MODE_INSERT, 1,     32'h5A5A_5A5A, pick_gap());
    send_request(MODE_INSERT, 3,     32'h8000_0001, pick_gap());
    send_request(MODE_INSERT, 5,     32'hDEAD_BEEF, pick_gap());
    send_request(MODE_READ,   0,     32'hFFFF_FFFF, pick_gap());
    send_request(MODE_READ,   1,     32'h0,        pick_gap());
    send_request(MODE_READ,   3,     32'h0,        pick_gap());
    send_request(MODE_READ,   4,     32'h0,        pick_gap());
    send_request(MODE_READ,   6'd63, 32'h0,        pick_gap());
    send_request(MODE_DELETE, 4,     32'h0,        pick_gap());
    send_request(MODE_DELETE, 0,     32'h0,        pick_gap());
    send_request(MODE_DELETE, 6'd63, 32'h0,        pick_gap());
    send_request(MODE_READ,   0,     32'h0,        pick_gap());
    send_request(MODE_SPARE_FIRST,               6'd42, 32'hFFFF_FFFF, pick_gap());
    send_request(MODE_SPARE_FIRST + MODE_W'(1), 6'd21, 32'h0,        pick_gap());
    send_request(MODE_SPARE_LAST,                6'd63, 32'h1357_9BDF, pick_gap());
    send_request(MODE_CLEAR,  0,     32'h0,        pick_gap());
    send_request(MODE_CLEAR,  6'd63, 32'hFFFF_FFFF, pick_gap());
    send_request(MODE_READ,   0,     32'h0,        pick_gap());

    // Random part in phases; growth phases run the list up to full
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % PHASE_LEN == 0) begin
        case ((i / PHASE_LEN) % 4)
          0: phase = PH_GROW;
          1: phase = PH_MIXED;
          2: phase = PH_SHRINK;
          default: phase = PH_BURST;
        endcase
      end
      mode = pick_mode();
      send_request(mode, pick_index(mode), pick_value(), pick_gap());
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
